/* design/pdmrs_pkg.sv */
package pdmrs_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int LSE_W       = SAMPLE_BITS + 1;
  localparam int PROD_W      = SAMPLE_BITS + 16;
  localparam int SUM_W       = PROD_W + 1;
  localparam int AMP_W       = 15;
  localparam int REF_W       = 16;
  localparam int LFSR_W      = 31;
  localparam int NC_SKIP     = 1600;
  localparam int SKIP_BLOCK  = 40;
  localparam int SKIP_BLOCKS = NC_SKIP / SKIP_BLOCK;
  localparam int CFG_W       = 15;

  localparam logic [7:0]       RE_LAST       = 8'd143;
  localparam logic [7:0]       RE_TOTAL      = 8'd144;
  localparam logic [8:0]       SSB_SUBC      = 9'd240;
  localparam logic [8:0]       SYM2_LOW_END  = 9'd48;
  localparam logic [8:0]       SYM2_GAP      = 9'd144;
  localparam logic [8:0]       RE_STRIDE     = 9'd4;
  localparam logic [1:0]       SYM_FIRST     = 2'd1;
  localparam logic [1:0]       SYM_SPLIT     = 2'd2;
  localparam logic [AMP_W-1:0] AMP_DEFAULT   = 15'd23170;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_NEXT  = 1'b1;

  typedef enum logic [1:0] {
    REG_CELL_ID   = 2'd0,
    REG_BEAM_MODE = 2'd1,
    REG_AMPLITUDE = 2'd2
  } cfg_reg_t;

  typedef logic [LFSR_W-1:0] lfsr_t;
  typedef logic [LFSR_W-1:0][LFSR_W-1:0] skip_mat_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [2:0] issb;
    logic [9:0] cell_id;
  } gold_ctl_t;

  function automatic lfsr_t x1_advance(lfsr_t v);
    return {v[0] ^ v[3], v[LFSR_W-1:1]};
  endfunction

  function automatic lfsr_t x2_advance(lfsr_t v);
    return {v[0] ^ v[1] ^ v[2] ^ v[3], v[LFSR_W-1:1]};
  endfunction

  function automatic lfsr_t x1_skipped();
    lfsr_t v;
    v = lfsr_t'(1);
    for (int a = 0; a < SKIP_BLOCKS; a++) begin
      for (int n = 0; n < SKIP_BLOCK; n++) v = x1_advance(v);
    end
    return v;
  endfunction

  // Row k holds the seed bits whose XOR gives bit k of x2 after the skip.
  function automatic skip_mat_t x2_skip_rows();
    skip_mat_t rows;
    lfsr_t     v;
    rows = '0;
    for (int j = 0; j < LFSR_W; j++) begin
      v    = '0;
      v[j] = 1'b1;
      for (int a = 0; a < SKIP_BLOCKS; a++) begin
        for (int n = 0; n < SKIP_BLOCK; n++) v = x2_advance(v);
      end
      for (int k = 0; k < LFSR_W; k++) rows[k][j] = v[k];
    end
    return rows;
  endfunction

  localparam lfsr_t     X1_SKIPPED   = x1_skipped();
  localparam skip_mat_t X2_SKIP_ROWS = x2_skip_rows();

endpackage

/* design/pdmrs_in_if.sv */
interface pdmrs_in_if import pdmrs_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [5:0]                    ssb_index;
  logic                          half_frame;
  logic signed [SAMPLE_BITS-1:0] rx_i;
  logic signed [SAMPLE_BITS-1:0] rx_q;

  modport source (output valid, kind, ssb_index, half_frame, rx_i, rx_q, input ready);
  modport sink   (input valid, kind, ssb_index, half_frame, rx_i, rx_q, output ready);
endinterface

/* design/pdmrs_out_if.sv */
interface pdmrs_out_if import pdmrs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              symbol;
  logic [7:0]              subcarrier;
  logic signed [REF_W-1:0] ref_i;
  logic signed [REF_W-1:0] ref_q;
  logic signed [LSE_W-1:0] lse_i;
  logic signed [LSE_W-1:0] lse_q;
  logic                    last;
  logic                    exhausted;

  modport source (output valid, symbol, subcarrier, ref_i, ref_q, lse_i, lse_q, last,
                  exhausted, input ready);
  modport sink   (input valid, symbol, subcarrier, ref_i, ref_q, lse_i, lse_q, last,
                  exhausted, output ready);
endinterface

/* design/pdmrs_gold.sv */
module pdmrs_gold import pdmrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  gold_ctl_t ctl,
  output logic [1:0] bits
);

  lfsr_t       x1_r, x1_nxt;
  lfsr_t       x2_r, x2_nxt;
  logic [3:0]  issb_p1;
  logic [8:0]  cid_q_p1;
  logic [12:0] seed_prod;
  logic [23:0] seed;
  lfsr_t       x2_seeded;

  always_comb begin
    issb_p1   = {1'b0, ctl.issb} + 4'd1;
    cid_q_p1  = {1'b0, ctl.cell_id[9:2]} + 9'd1;
    seed_prod = {9'd0, issb_p1} * {4'd0, cid_q_p1};
    seed      = {seed_prod, 11'd0} + {14'd0, issb_p1, 6'd0} + {22'd0, ctl.cell_id[1:0]};
    // The 1600-step skip is linear over GF(2), so each bit is a fixed XOR of seed bits.
    for (int k = 0; k < LFSR_W; k++) begin
      x2_seeded[k] = ^({7'd0, seed} & X2_SKIP_ROWS[k]);
    end
  end

  // Bit 0 goes to the real part, bit 1 to the imaginary part.
  assign bits = {x1_r[1] ^ x2_r[1], x1_r[0] ^ x2_r[0]};

  always_comb begin
    x1_nxt = x1_r;
    x2_nxt = x2_r;
    if (ctl.load) begin
      x1_nxt = X1_SKIPPED;
      x2_nxt = x2_seeded;
    end else if (ctl.step) begin
      x1_nxt = {x1_r[1] ^ x1_r[4], x1_r[0] ^ x1_r[3], x1_r[LFSR_W-1:2]};
      x2_nxt = {x2_r[1] ^ x2_r[2] ^ x2_r[3] ^ x2_r[4],
                x2_r[0] ^ x2_r[1] ^ x2_r[2] ^ x2_r[3], x2_r[LFSR_W-1:2]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
    end else begin
      x1_r <= x1_nxt;
      x2_r <= x2_nxt;
    end
  end

endmodule

/* design/pbch_dmrs_generate_and_estimate_top.sv */
// PBCH DMRS generator with least-squares channel estimate.
// Input channel in_ch: a word with kind 0 starts a sequence for the given SSB index and
// half-frame bit and yields no result; a word with kind 1 asks for the next of the 144
// DMRS elements and carries the received sample for it. Every kind-1 word yields exactly
// one output word: symbol, subcarrier, QPSK reference, rx*conj(ref)>>15 and last. When no
// sequence is running (after reset or after the 144th element) the output word has
// exhausted set and all other fields zero.
// Configuration (cell_id, beam_mode, amplitude) is written through cfg_we/cfg_index/cfg_data
// while the block is idle. Amplitude zero selects 1/sqrt2.
// Pipeline: input register, a step stage that advances the sequence state and forms the
// two sample-by-amplitude products, and an output register. Each result passes through each
// of them in turn, and one word can be accepted every cycle while the receiver takes the output.
// The sequence registers advance by two bits per element; a start loads them directly through a
// fixed XOR network that applies the 1600-bit skip.
// When the receiver stalls, words back up stage by stage and in_ch.ready falls once the
// pipeline is full; nothing is dropped. Reset is synchronous and restores the register
// defaults with no sequence running.
module pbch_dmrs_generate_and_estimate_top import pdmrs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  pdmrs_in_if.sink         in_ch,
  pdmrs_out_if.source      out_ch,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // Configuration.
  logic [9:0]       cell_id_r;
  logic             beam_mode_r;
  logic [AMP_W-1:0] amplitude_r;

  // Input register.
  logic                          s1_valid_r;
  logic                          s1_kind_r;
  logic [5:0]                    s1_ssb_r;
  logic                          s1_hf_r;
  logic signed [SAMPLE_BITS-1:0] s1_rx_i_r;
  logic signed [SAMPLE_BITS-1:0] s1_rx_q_r;

  // Walk state.
  logic [7:0] count_r, count_nxt;
  logic [1:0] sym_r, sym_nxt;
  logic [7:0] sc_r, sc_nxt;
  logic       active_r, active_nxt;

  // Step stage.
  logic                     s2_valid_r;
  logic                     s2_exh_r;
  logic                     s2_last_r;
  logic [1:0]               s2_sym_r;
  logic [7:0]               s2_sc_r;
  logic [1:0]               s2_bits_r;
  logic [AMP_W-1:0]         s2_amp_r;
  logic signed [PROD_W-1:0] s2_p_i_r;
  logic signed [PROD_W-1:0] s2_p_q_r;

  // Output register.
  logic                    out_valid_r;
  logic [1:0]              out_sym_r;
  logic [7:0]              out_sc_r;
  logic signed [REF_W-1:0] out_ref_i_r, out_ref_i_nxt;
  logic signed [REF_W-1:0] out_ref_q_r, out_ref_q_nxt;
  logic signed [LSE_W-1:0] out_lse_i_r, out_lse_i_nxt;
  logic signed [LSE_W-1:0] out_lse_q_r, out_lse_q_nxt;
  logic                    out_last_r;
  logic                    out_exh_r;

  logic             out_load, s2_free, s1_fire, s2_load, step;
  logic [AMP_W-1:0] amp_eff;
  logic [1:0]       gold_bits;
  gold_ctl_t        gold_ctl;
  logic [8:0]       k_walk;

  assign out_load = s2_valid_r && (!out_valid_r || out_ch.ready);
  assign s2_free  = !s2_valid_r || out_load;
  assign s1_fire  = s1_valid_r && (s1_kind_r == KIND_START || s2_free);
  assign s2_load  = s1_fire && s1_kind_r == KIND_NEXT;
  assign step     = s2_load && active_r;
  assign in_ch.ready = !s1_valid_r || s1_fire;

  assign amp_eff = (amplitude_r == '0) ? AMP_DEFAULT : amplitude_r;

  always_comb begin
    gold_ctl.load    = s1_fire && s1_kind_r == KIND_START;
    gold_ctl.step    = step;
    gold_ctl.issb    = beam_mode_r ? s1_ssb_r[2:0] : {s1_hf_r, s1_ssb_r[1:0]};
    gold_ctl.cell_id = cell_id_r;
  end

  pdmrs_gold u_gold (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (gold_ctl),
    .bits  (gold_bits)
  );

  // Walk to the next element; symbol 2 jumps over the PBCH data block in the middle.
  always_comb begin
    count_nxt  = count_r;
    sym_nxt    = sym_r;
    sc_nxt     = sc_r;
    active_nxt = active_r;
    k_walk     = {1'b0, sc_r} + RE_STRIDE;
    if (sym_r == SYM_SPLIT && {1'b0, sc_r} < SYM2_LOW_END && k_walk >= SYM2_LOW_END) begin
      k_walk = k_walk + SYM2_GAP;
    end
    if (gold_ctl.load) begin
      count_nxt  = '0;
      sym_nxt    = SYM_FIRST;
      sc_nxt     = {6'd0, cell_id_r[1:0]};
      active_nxt = 1'b1;
    end else if (step) begin
      count_nxt = count_r + 8'd1;
      if (count_r == RE_LAST) begin
        active_nxt = 1'b0;
      end
      if (k_walk >= SSB_SUBC) begin
        sc_nxt  = 8'(k_walk - SSB_SUBC);
        sym_nxt = sym_r + 2'd1;
      end else begin
        sc_nxt = k_walk[7:0];
      end
    end
  end

  // Output arithmetic: rx*conj(ref) with ref = +/-A on each rail.
  always_comb begin
    logic signed [SUM_W-1:0] p_i, p_q, t_ii, t_qq, t_qi, t_iq, sum_i, sum_q;
    p_i   = SUM_W'(s2_p_i_r);
    p_q   = SUM_W'(s2_p_q_r);
    t_ii  = s2_bits_r[0] ? -p_i : p_i;
    t_qq  = s2_bits_r[1] ? -p_q : p_q;
    t_qi  = s2_bits_r[0] ? -p_q : p_q;
    t_iq  = s2_bits_r[1] ? -p_i : p_i;
    sum_i = t_ii + t_qq;
    sum_q = t_qi - t_iq;
    out_ref_i_nxt = s2_bits_r[0] ? -$signed({1'b0, s2_amp_r}) : $signed({1'b0, s2_amp_r});
    out_ref_q_nxt = s2_bits_r[1] ? -$signed({1'b0, s2_amp_r}) : $signed({1'b0, s2_amp_r});
    out_lse_i_nxt = sum_i[15 +: LSE_W];
    out_lse_q_nxt = sum_q[15 +: LSE_W];
    if (s2_exh_r) begin
      out_ref_i_nxt = '0;
      out_ref_q_nxt = '0;
      out_lse_i_nxt = '0;
      out_lse_q_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_id_r   <= '0;
      beam_mode_r <= 1'b0;
      amplitude_r <= AMP_DEFAULT;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      sym_r       <= SYM_FIRST;
      sc_r        <= '0;
      active_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CELL_ID:   cell_id_r   <= cfg_data[9:0];
          REG_BEAM_MODE: beam_mode_r <= cfg_data[0];
          REG_AMPLITUDE: amplitude_r <= cfg_data[AMP_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s2_load) begin
        s2_valid_r <= 1'b1;
      end else if (out_load) begin
        s2_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      count_r  <= count_nxt;
      sym_r    <= sym_nxt;
      sc_r     <= sc_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      s1_kind_r <= in_ch.kind;
      s1_ssb_r  <= in_ch.ssb_index;
      s1_hf_r   <= in_ch.half_frame;
      s1_rx_i_r <= in_ch.rx_i;
      s1_rx_q_r <= in_ch.rx_q;
    end
    if (s2_load) begin
      s2_exh_r  <= !active_r;
      s2_last_r <= active_r && count_r == RE_LAST;
      s2_sym_r  <= active_r ? sym_r : 2'd0;
      s2_sc_r   <= active_r ? sc_r : 8'd0;
      s2_bits_r <= gold_bits;
      s2_amp_r  <= amp_eff;
      s2_p_i_r  <= s1_rx_i_r * $signed({1'b0, amp_eff});
      s2_p_q_r  <= s1_rx_q_r * $signed({1'b0, amp_eff});
    end
    if (out_load) begin
      out_sym_r   <= s2_sym_r;
      out_sc_r    <= s2_sc_r;
      out_ref_i_r <= out_ref_i_nxt;
      out_ref_q_r <= out_ref_q_nxt;
      out_lse_i_r <= out_lse_i_nxt;
      out_lse_q_r <= out_lse_q_nxt;
      out_last_r  <= s2_last_r;
      out_exh_r   <= s2_exh_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.symbol     = out_sym_r;
  assign out_ch.subcarrier = out_sc_r;
  assign out_ch.ref_i      = out_ref_i_r;
  assign out_ch.ref_q      = out_ref_q_r;
  assign out_ch.lse_i      = out_lse_i_r;
  assign out_ch.lse_q      = out_lse_q_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.exhausted  = out_exh_r;

  a_last_not_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> !out_exh_r)
    else $error("last element flagged as exhausted");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> count_r < RE_TOTAL && sym_r != 2'd0)
    else $error("walk state out of range while a sequence runs");

  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    step && count_r == RE_LAST |=> !active_r)
    else $error("sequence still running after its last element");

  a_start_resets_walk: assert property (@(posedge clk) disable iff (!rst_n)
    gold_ctl.load |=> active_r && count_r == 8'd0 && sym_r == SYM_FIRST)
    else $error("start did not reset the walk");

  a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_exh_r |-> out_ref_i_r == '0 && out_ref_q_r == '0 && out_lse_i_r == '0)
    else $error("exhausted word carries nonzero fields");

endmodule
